[rtl/fwus_pkg.sv]
// Shared types and codes for the order queue with undo stack.
package fwus_pkg;

  localparam logic [2:0] CMD_PLACE      = 3'd0;
  localparam logic [2:0] CMD_PROCESS    = 3'd1;
  localparam logic [2:0] CMD_UNDO       = 3'd2;
  localparam logic [2:0] CMD_VIEW_PEND  = 3'd3;
  localparam logic [2:0] CMD_VIEW_SERV  = 3'd4;

  localparam logic [2:0] ST_OK          = 3'd0;
  localparam logic [2:0] ST_NONE_PEND   = 3'd1;
  localparam logic [2:0] ST_NONE_SERV   = 3'd2;
  localparam logic [2:0] ST_PEND_FULL   = 3'd3;
  localparam logic [2:0] ST_SERV_FULL   = 3'd4;

  typedef enum logic [2:0] {
    OP_PLACE,
    OP_PROCESS,
    OP_UNDO,
    OP_VIEW_PEND,
    OP_VIEW_SERV
  } op_e;

  typedef struct packed {
    logic [2:0]  command;
    logic [15:0] item_code;
    logic [23:0] price_cents;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [15:0] order_id;
    logic [15:0] item_code_res;
    logic [23:0] price_cents_res;
    logic [4:0]  entry_count;
    logic        last;
  } out_item_t;

  typedef struct packed {
    logic [15:0] id;
    logic [15:0] code;
    logic [23:0] price;
  } entry_t;

  typedef struct packed {
    op_e         op;
    logic [15:0] item_code;
    logic [23:0] price_cents;
  } cmd_t;

endpackage

[rtl/fifo_with_undo_stack.sv]
// Order queue with undo stack: a FIFO of pending entries and a LIFO of served
// entries. Commands enter a two-entry command buffer and are carried out one at
// a time by the back end, which owns both single-port-read memories and a
// result register. Place and error results are given directly; process and
// undo first read the memory, then write and give the result; a view gives
// one result per listed entry, each read in turn from the memory being
// walked. Output stall holds the back end. Codes 5 to 7 are taken and give
// no result.
module fifo_with_undo_stack import fwus_pkg::*; #(
  parameter int QUEUE_DEPTH = 16,
  parameter int STACK_DEPTH = 16
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  in_item_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_item_t out_data_o
);

  logic cmd_valid;
  logic cmd_pop;
  cmd_t cmd;

  fwus_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .cmd_valid_o (cmd_valid),
    .cmd_pop_i   (cmd_pop),
    .cmd_o       (cmd)
  );

  fwus_back #(
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .STACK_DEPTH (STACK_DEPTH)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (cmd_valid),
    .cmd_pop_o   (cmd_pop),
    .cmd_i       (cmd),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule

[rtl/fwus_front.sv]
// Front end: accepts transfers, decodes commands and buffers them for the back end.
module fwus_front import fwus_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  input  in_item_t in_data_i,
  output logic     cmd_valid_o,
  input  logic     cmd_pop_i,
  output cmd_t     cmd_o
);

  cmd_t       slot_q [2];
  logic       wr_q, wr_d, rd_q, rd_d;
  logic [1:0] cnt_q, cnt_d;
  logic       known;
  op_e        op;
  logic       push;
  logic       pop;

  always_comb begin
    known = 1'b1;
    op    = OP_PLACE;
    unique case (in_data_i.command)
      CMD_PLACE:     op = OP_PLACE;
      CMD_PROCESS:   op = OP_PROCESS;
      CMD_UNDO:      op = OP_UNDO;
      CMD_VIEW_PEND: op = OP_VIEW_PEND;
      CMD_VIEW_SERV: op = OP_VIEW_SERV;
      default:       known = 1'b0;
    endcase
  end

  assign in_stall_o  = (cnt_q == 2'd2);
  assign push        = in_valid_i && !in_stall_o && known;
  assign cmd_valid_o = (cnt_q != 2'd0);
  assign pop         = cmd_pop_i && cmd_valid_o;
  assign cmd_o       = slot_q[rd_q];

  always_comb begin
    wr_d  = push ? ~wr_q : wr_q;
    rd_d  = pop ? ~rd_q : rd_q;
    cnt_d = cnt_q + 2'(push) - 2'(pop);
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      slot_q[wr_q] <= '{op: op, item_code: in_data_i.item_code,
                        price_cents: in_data_i.price_cents};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

endmodule

[rtl/fwus_back.sv]
// Back end: queue and stack storage, command execution and result register.
module fwus_back import fwus_pkg::*; #(
  parameter int QUEUE_DEPTH = 16,
  parameter int STACK_DEPTH = 16
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      cmd_valid_i,
  output logic      cmd_pop_o,
  input  cmd_t      cmd_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_item_t out_data_o
);

  localparam int QA  = $clog2(QUEUE_DEPTH);
  localparam int SA  = $clog2(STACK_DEPTH);
  localparam int QCW = $clog2(QUEUE_DEPTH + 1);
  localparam int SCW = $clog2(STACK_DEPTH + 1);
  localparam int IW  = (QCW > SCW) ? QCW : SCW;

  localparam logic S_IDLE = 1'b0;
  localparam logic S_DATA = 1'b1;

  entry_t pmem [QUEUE_DEPTH];
  entry_t smem [STACK_DEPTH];
  entry_t prdata_q, srdata_q;

  logic           state_q, state_d;
  logic [QA-1:0]  head_q, head_d, tail_q, tail_d, pwalk_q, pwalk_d;
  logic [SA-1:0]  swalk_q, swalk_d;
  logic [QCW-1:0] pcnt_q, pcnt_d;
  logic [SCW-1:0] scnt_q, scnt_d;
  logic [IW-1:0]  idx_q, idx_d;
  logic [15:0]    id_q, id_d;
  logic           out_valid_q, out_valid_d;
  out_item_t      out_q, out_d;

  logic           prd_en, srd_en, pwr_en, swr_en;
  logic [QA-1:0]  prd_addr, pwr_addr;
  logic [SA-1:0]  srd_addr, swr_addr;
  entry_t         pwr_data, swr_data;
  logic           out_free, emit, pend_full, serv_full, is_last;
  entry_t         new_entry;

  function automatic logic [QA-1:0] ring_next(input logic [QA-1:0] p);
    return (p == QA'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  function automatic out_item_t mk_res(input logic [2:0] st, input entry_t e,
                                       input logic [4:0] cnt, input logic lst);
    out_item_t r;
    r.status          = st;
    r.order_id        = e.id;
    r.item_code_res   = e.code;
    r.price_cents_res = e.price;
    r.entry_count     = cnt;
    r.last            = lst;
    return r;
  endfunction

  assign out_free  = !out_valid_q || !out_stall_i;
  assign pend_full = (pcnt_q == QCW'(QUEUE_DEPTH));
  assign serv_full = (scnt_q == SCW'(STACK_DEPTH));
  assign new_entry = '{id: id_q + 16'd1, code: cmd_i.item_code, price: cmd_i.price_cents};

  always_comb begin
    state_d   = state_q;
    head_d    = head_q;
    tail_d    = tail_q;
    pwalk_d   = pwalk_q;
    swalk_d   = swalk_q;
    pcnt_d    = pcnt_q;
    scnt_d    = scnt_q;
    idx_d     = idx_q;
    id_d      = id_q;
    prd_en    = 1'b0;
    srd_en    = 1'b0;
    pwr_en    = 1'b0;
    swr_en    = 1'b0;
    prd_addr  = head_q;
    srd_addr  = SA'(scnt_q - 1'b1);
    pwr_addr  = tail_q;
    swr_addr  = SA'(scnt_q);
    pwr_data  = new_entry;
    swr_data  = prdata_q;
    emit      = 1'b0;
    cmd_pop_o = 1'b0;
    out_d     = mk_res(ST_OK, '0, 5'd0, 1'b1);
    is_last   = 1'b0;

    if (cmd_valid_i && out_free) begin
      unique case (state_q)
        S_IDLE: begin
          unique case (cmd_i.op)
            OP_PLACE: begin
              emit      = 1'b1;
              cmd_pop_o = 1'b1;
              if (pend_full) begin
                out_d = mk_res(ST_PEND_FULL, '0, 5'(pcnt_q), 1'b1);
              end else begin
                id_d   = new_entry.id;
                pwr_en = 1'b1;
                tail_d = ring_next(tail_q);
                pcnt_d = pcnt_q + 1'b1;
                out_d  = mk_res(ST_OK, new_entry, 5'(pcnt_d), 1'b1);
              end
            end
            OP_PROCESS: begin
              if (pcnt_q == '0) begin
                emit      = 1'b1;
                cmd_pop_o = 1'b1;
                out_d     = mk_res(ST_NONE_PEND, '0, 5'd0, 1'b1);
              end else if (serv_full) begin
                emit      = 1'b1;
                cmd_pop_o = 1'b1;
                out_d     = mk_res(ST_SERV_FULL, '0, 5'(scnt_q), 1'b1);
              end else begin
                prd_en  = 1'b1;
                state_d = S_DATA;
              end
            end
            OP_UNDO: begin
              if (scnt_q == '0) begin
                emit      = 1'b1;
                cmd_pop_o = 1'b1;
                out_d     = mk_res(ST_NONE_SERV, '0, 5'd0, 1'b1);
              end else if (pend_full) begin
                emit      = 1'b1;
                cmd_pop_o = 1'b1;
                out_d     = mk_res(ST_PEND_FULL, '0, 5'(pcnt_q), 1'b1);
              end else begin
                srd_en  = 1'b1;
                state_d = S_DATA;
              end
            end
            OP_VIEW_PEND: begin
              if (pcnt_q == '0) begin
                emit      = 1'b1;
                cmd_pop_o = 1'b1;
                out_d     = mk_res(ST_NONE_PEND, '0, 5'd0, 1'b1);
              end else begin
                prd_en  = 1'b1;
                pwalk_d = ring_next(head_q);
                idx_d   = IW'(1);
                state_d = S_DATA;
              end
            end
            OP_VIEW_SERV: begin
              if (scnt_q == '0) begin
                emit      = 1'b1;
                cmd_pop_o = 1'b1;
                out_d     = mk_res(ST_NONE_SERV, '0, 5'd0, 1'b1);
              end else begin
                srd_en  = 1'b1;
                swalk_d = SA'(scnt_q - 2'd2);
                idx_d   = IW'(1);
                state_d = S_DATA;
              end
            end
            default: ;
          endcase
        end
        S_DATA: begin
          emit = 1'b1;
          unique case (cmd_i.op)
            OP_PROCESS: begin
              swr_en    = 1'b1;
              head_d    = ring_next(head_q);
              pcnt_d    = pcnt_q - 1'b1;
              scnt_d    = scnt_q + 1'b1;
              out_d     = mk_res(ST_OK, prdata_q, 5'(scnt_d), 1'b1);
              cmd_pop_o = 1'b1;
              state_d   = S_IDLE;
            end
            OP_UNDO: begin
              pwr_en    = 1'b1;
              pwr_data  = srdata_q;
              tail_d    = ring_next(tail_q);
              pcnt_d    = pcnt_q + 1'b1;
              scnt_d    = scnt_q - 1'b1;
              out_d     = mk_res(ST_OK, srdata_q, 5'(pcnt_d), 1'b1);
              cmd_pop_o = 1'b1;
              state_d   = S_IDLE;
            end
            OP_VIEW_PEND: begin
              is_last = (idx_q == IW'(pcnt_q));
              out_d   = mk_res(ST_OK, prdata_q, 5'(pcnt_q), is_last);
              if (is_last) begin
                cmd_pop_o = 1'b1;
                state_d   = S_IDLE;
              end else begin
                prd_en   = 1'b1;
                prd_addr = pwalk_q;
                pwalk_d  = ring_next(pwalk_q);
                idx_d    = idx_q + 1'b1;
              end
            end
            OP_VIEW_SERV: begin
              is_last = (idx_q == IW'(scnt_q));
              out_d   = mk_res(ST_OK, srdata_q, 5'(scnt_q), is_last);
              if (is_last) begin
                cmd_pop_o = 1'b1;
                state_d   = S_IDLE;
              end else begin
                srd_en   = 1'b1;
                srd_addr = swalk_q;
                swalk_d  = swalk_q - 1'b1;
                idx_d    = idx_q + 1'b1;
              end
            end
            default: begin
              emit      = 1'b0;
              cmd_pop_o = 1'b1;
              state_d   = S_IDLE;
            end
          endcase
        end
        default: state_d = S_IDLE;
      endcase
    end

    if (emit) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pwr_en) begin
      pmem[pwr_addr] <= pwr_data;
    end
    if (prd_en) begin
      prdata_q <= pmem[prd_addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (swr_en) begin
      smem[swr_addr] <= swr_data;
    end
    if (srd_en) begin
      srdata_q <= smem[srd_addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      out_q <= out_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      head_q      <= '0;
      tail_q      <= '0;
      pwalk_q     <= '0;
      swalk_q     <= '0;
      pcnt_q      <= '0;
      scnt_q      <= '0;
      idx_q       <= '0;
      id_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      head_q      <= head_d;
      tail_q      <= tail_d;
      pwalk_q     <= pwalk_d;
      swalk_q     <= swalk_d;
      pcnt_q      <= pcnt_d;
      scnt_q      <= scnt_d;
      idx_q       <= idx_d;
      id_q        <= id_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

[bench/tb.sv]
// Self-checking testbench for fifo_with_undo_stack: random command streams against a predictor.
module tb;
  import fwus_pkg::*;

  localparam int QD          = 16;
  localparam int SD          = 16;
  localparam int HOLD_CYCLES = 150;
  localparam int MAX_SHOWN   = 10;
  localparam logic [2:0] CMD_UNUSED_LO = CMD_VIEW_SERV + 3'd1;
  localparam logic [2:0] CMD_UNUSED_HI = 3'd7;

  typedef enum {K_ORDER, K_MODE, K_HOLD, K_DRAIN} step_kind_e;

  typedef struct {
    step_kind_e kind;
    in_item_t   data;
    int         snd_pct;
    int         rcv_pct;
  } step_t;

  logic      clk_i = 1'b0;
  logic      rst_ni = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_stall;
  in_item_t  in_data = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_item_t out_data;

  step_t     steps_q[$];
  out_item_t exp_q[$];

  // predictor state
  entry_t      pend_mem[QD];
  int          pend_head = 0;
  int          pend_tail = 0;
  int          pend_num = 0;
  entry_t      serv_mem[SD];
  int          serv_num = 0;
  logic [15:0] id_ctr = '0;

  // occupancy mirror used only to steer stimulus
  int gen_pend = 0;
  int gen_serv = 0;

  logic in_took = 1'b0;
  int   snd_pct = 0;
  int   rcv_pct = 0;
  int   hold_reqs = 0;
  int   hold_seen = 0;
  int   hold_left = 0;
  int   err_cnt = 0;

  fifo_with_undo_stack #(
    .QUEUE_DEPTH(QD),
    .STACK_DEPTH(SD)
  ) uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_data_o (out_data)
  );

  always #5 clk_i = ~clk_i;

  task automatic queue_result(input logic [2:0] st, input entry_t e, input int cnt,
                              input logic lst);
    out_item_t r;
    r.status          = st;
    r.order_id        = e.id;
    r.item_code_res   = e.code;
    r.price_cents_res = e.price;
    r.entry_count     = 5'(cnt);
    r.last            = lst;
    exp_q.push_back(r);
  endtask

  task automatic predict_orders(input in_item_t it);
    entry_t e;
    int     k;
    int     p;
    case (it.command)
      CMD_PLACE: begin
        if (pend_num >= QD) begin
          queue_result(ST_PEND_FULL, '0, pend_num, 1'b1);
        end else begin
          id_ctr = id_ctr + 16'd1;
          e = {id_ctr, it.item_code, it.price_cents};
          pend_mem[pend_tail] = e;
          pend_tail = (pend_tail + 1) % QD;
          pend_num++;
          queue_result(ST_OK, e, pend_num, 1'b1);
        end
      end
      CMD_PROCESS: begin
        if (pend_num == 0) begin
          queue_result(ST_NONE_PEND, '0, 0, 1'b1);
        end else if (serv_num >= SD) begin
          queue_result(ST_SERV_FULL, '0, serv_num, 1'b1);
        end else begin
          e = pend_mem[pend_head];
          pend_head = (pend_head + 1) % QD;
          pend_num--;
          serv_mem[serv_num] = e;
          serv_num++;
          queue_result(ST_OK, e, serv_num, 1'b1);
        end
      end
      CMD_UNDO: begin
        if (serv_num == 0) begin
          queue_result(ST_NONE_SERV, '0, 0, 1'b1);
        end else if (pend_num >= QD) begin
          queue_result(ST_PEND_FULL, '0, pend_num, 1'b1);
        end else begin
          serv_num--;
          e = serv_mem[serv_num];
          pend_mem[pend_tail] = e;
          pend_tail = (pend_tail + 1) % QD;
          pend_num++;
          queue_result(ST_OK, e, pend_num, 1'b1);
        end
      end
      CMD_VIEW_PEND: begin
        if (pend_num == 0) begin
          queue_result(ST_NONE_PEND, '0, 0, 1'b1);
        end else begin
          p = pend_head;
          for (k = 0; k < pend_num; k++) begin
            queue_result(ST_OK, pend_mem[p], pend_num, k + 1 == pend_num);
            p = (p + 1) % QD;
          end
        end
      end
      CMD_VIEW_SERV: begin
        if (serv_num == 0) begin
          queue_result(ST_NONE_SERV, '0, 0, 1'b1);
        end else begin
          for (k = 0; k < serv_num; k++) begin
            queue_result(ST_OK, serv_mem[serv_num - 1 - k], serv_num, k + 1 == serv_num);
          end
        end
      end
      default: begin
      end
    endcase
  endtask

  task automatic add_cmd(input logic [2:0] c, input logic [15:0] code,
                         input logic [23:0] price);
    step_t s;
    s.kind    = K_ORDER;
    s.data    = {c, code, price};
    s.snd_pct = 0;
    s.rcv_pct = 0;
    steps_q.push_back(s);
    case (c)
      CMD_PLACE: if (gen_pend < QD) gen_pend++;
      CMD_PROCESS: begin
        if (gen_pend > 0 && gen_serv < SD) begin
          gen_pend--;
          gen_serv++;
        end
      end
      CMD_UNDO: begin
        if (gen_serv > 0 && gen_pend < QD) begin
          gen_serv--;
          gen_pend++;
        end
      end
      default: begin
      end
    endcase
  endtask

  task automatic add_mark(input step_kind_e k, input int sp, input int rp);
    step_t s;
    s.kind    = k;
    s.data    = '0;
    s.snd_pct = sp;
    s.rcv_pct = rp;
    steps_q.push_back(s);
  endtask

  task automatic add_rand(input logic [2:0] c);
    add_cmd(c, 16'($urandom_range(0, 16'hFFFF)), 24'($urandom_range(0, 24'hFFFFFF)));
  endtask

  // bursts of one command push the queue and stack to their full and empty ends;
  // cap bounds the total entries so that both structures keep moving
  task automatic gen_random(input int n, input int cap);
    int         made;
    int         len;
    int         pick;
    logic [2:0] c;
    made = 0;
    while (made < n) begin
      pick = $urandom_range(0, 99);
      if (pick < 25) c = CMD_PLACE;
      else if (pick < 55) c = CMD_PROCESS;
      else if (pick < 80) c = CMD_UNDO;
      else if (pick < 88) c = CMD_VIEW_PEND;
      else if (pick < 96) c = CMD_VIEW_SERV;
      else c = 3'($urandom_range(int'(CMD_UNUSED_LO), int'(CMD_UNUSED_HI)));
      if (c == CMD_PLACE || c == CMD_PROCESS || c == CMD_UNDO)
        len = ($urandom_range(0, 3) == 0) ? $urandom_range(6, 18) : $urandom_range(1, 3);
      else
        len = 1;
      repeat (len) begin
        if (made < n) begin
          if (c == CMD_PLACE && gen_pend + gen_serv >= cap)
            c = ($urandom_range(0, 1) == 0) ? CMD_PROCESS : CMD_UNDO;
          add_rand(c);
          made++;
        end
      end
    end
  endtask

  // driver
  always @(negedge clk_i) begin
    logic  nv;
    step_t s;
    if (rst_ni && !(in_valid && !in_took)) begin
      nv = 1'b0;
      if (steps_q.size() != 0) begin
        s = steps_q[0];
        case (s.kind)
          K_MODE: begin
            s = steps_q.pop_front();
            snd_pct = s.snd_pct;
            rcv_pct <= s.rcv_pct;
          end
          K_HOLD: begin
            s = steps_q.pop_front();
            hold_reqs <= hold_reqs + 1;
          end
          K_DRAIN: begin
            if (exp_q.size() == 0) s = steps_q.pop_front();
          end
          default: begin
            if ($urandom_range(0, 99) >= snd_pct) begin
              s = steps_q.pop_front();
              nv = 1'b1;
              in_data <= s.data;
            end
          end
        endcase
      end
      in_valid <= nv;
    end
  end

  // result side stall, with a long hold-off on request
  always @(negedge clk_i) begin
    logic ns;
    if (hold_left > 0) begin
      hold_left = hold_left - 1;
      ns = 1'b1;
    end else if (hold_seen != hold_reqs) begin
      hold_seen = hold_reqs;
      hold_left = HOLD_CYCLES - 1;
      ns = 1'b1;
    end else begin
      ns = ($urandom_range(0, 99) < rcv_pct);
    end
    out_stall <= ns;
  end

  // monitor: predict on each input transfer, check each output transfer
  always @(posedge clk_i) begin
    out_item_t want;
    out_item_t got;
    in_took = 1'b0;
    if (rst_ni) begin
      if (in_valid && !in_stall) begin
        in_took = 1'b1;
        predict_orders(in_data);
      end
      if (out_valid && !out_stall) begin
        got = out_data;
        if (exp_q.size() == 0) begin
          if (err_cnt < MAX_SHOWN)
            $display("unexpected result: st=%0d id=%0d code=%0h price=%0h cnt=%0d last=%0b",
                     got.status, got.order_id, got.item_code_res, got.price_cents_res,
                     got.entry_count, got.last);
          err_cnt++;
        end else begin
          want = exp_q.pop_front();
          if (got.status !== want.status || got.order_id !== want.order_id ||
              got.item_code_res !== want.item_code_res ||
              got.price_cents_res !== want.price_cents_res ||
              got.entry_count !== want.entry_count || got.last !== want.last) begin
            if (err_cnt < MAX_SHOWN) begin
              $display("mismatch: exp st=%0d id=%0d code=%0h price=%0h cnt=%0d last=%0b",
                       want.status, want.order_id, want.item_code_res, want.price_cents_res,
                       want.entry_count, want.last);
              $display("          got st=%0d id=%0d code=%0h price=%0h cnt=%0d last=%0b",
                       got.status, got.order_id, got.item_code_res, got.price_cents_res,
                       got.entry_count, got.last);
            end
            err_cnt++;
          end
        end
      end
    end
  end

  initial begin
    add_mark(K_MODE, 12, 62);
    // empty structures, unused codes, field extremes, short walk through every command
    add_rand(CMD_VIEW_PEND);
    add_rand(CMD_VIEW_SERV);
    add_rand(CMD_PROCESS);
    add_rand(CMD_UNDO);
    add_rand(CMD_UNUSED_LO);
    add_rand(CMD_UNUSED_LO + 3'd1);
    add_rand(CMD_UNUSED_HI);
    add_cmd(CMD_PLACE, '0, '0);
    add_cmd(CMD_PLACE, '1, '1);
    add_rand(CMD_PLACE);
    add_rand(CMD_VIEW_PEND);
    add_rand(CMD_PROCESS);
    add_rand(CMD_PROCESS);
    add_rand(CMD_VIEW_SERV);
    add_rand(CMD_UNDO);
    add_rand(CMD_VIEW_PEND);
    add_rand(CMD_VIEW_SERV);
    add_mark(K_HOLD, 0, 0);
    gen_random(100, 26);
    add_mark(K_MODE, 62, 12);
    gen_random(50, 30);
    add_mark(K_DRAIN, 0, 0);
    gen_random(50, 30);
    add_mark(K_MODE, 0, 0);
    gen_random(100, 32);

    repeat (5) @(negedge clk_i);
    rst_ni <= 1'b1;

    forever begin
      @(posedge clk_i);
      #1;
      if (steps_q.size() == 0 && !in_valid && exp_q.size() == 0) break;
    end
    repeat (40) @(posedge clk_i);
    if (err_cnt == 0 && exp_q.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("status: fail");
    $finish;
  end

endmodule
